/* hdl/fspq_pkg.sv */
// Shared types and constants for the four-level strict priority queue.
package fspq_pkg;

  localparam int NUM_LEVELS = 4;
  localparam int LEVEL_W = 2;
  localparam int CMD_W = 2;
  localparam int PRIO_W = 3;
  localparam int TAG_PORT_W = 16;
  localparam logic [LEVEL_W-1:0] TOP_LEVEL = 2'd3;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_FRONT  = 2'd1,
    CMD_POP    = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Result fields handed from the level controller to the result register.
  typedef struct packed {
    status_t              status;
    logic [LEVEL_W-1:0]   level;
    logic                 bad;
    logic                 empty;
    logic                 pop_hit;
  } fspq_result_t;

endpackage

/* hdl/fspq_level_ctl.sv */
// Head and count registers of the four levels, with command decode and level select.
module fspq_level_ctl import fspq_pkg::*; #(
  parameter int LEVEL_DEPTH = 16,
  parameter int HEAD_W = $clog2(LEVEL_DEPTH),
  parameter int ADDR_W = LEVEL_W + HEAD_W
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                go,
  input  logic [CMD_W-1:0]    cmd,
  input  logic [PRIO_W-1:0]   prio,
  output logic                we,
  output logic [ADDR_W-1:0]   waddr,
  output logic [ADDR_W-1:0]   raddr,
  output fspq_result_t        res
);

  localparam int CNT_W = $clog2(LEVEL_DEPTH + 1);
  localparam int SUM_W = HEAD_W + 1;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(LEVEL_DEPTH);
  localparam logic [SUM_W-1:0] SUM_DEPTH = SUM_W'(LEVEL_DEPTH);
  localparam logic [HEAD_W-1:0] HEAD_LAST = HEAD_W'(LEVEL_DEPTH - 1);

  logic [HEAD_W-1:0] head [NUM_LEVELS];
  logic [HEAD_W-1:0] head_next [NUM_LEVELS];
  logic [CNT_W-1:0]  count [NUM_LEVELS];
  logic [CNT_W-1:0]  count_next [NUM_LEVELS];

  logic [LEVEL_W-1:0] ins_lvl;
  logic [LEVEL_W-1:0] pop_lvl;
  logic               pop_any;
  logic [SUM_W-1:0]   back_sum;
  logic [HEAD_W-1:0]  back_slot;
  logic [HEAD_W-1:0]  front_slot;
  logic [HEAD_W-1:0]  pop_head_inc;

  assign ins_lvl = prio[PRIO_W-1] ? TOP_LEVEL : prio[LEVEL_W-1:0];

  // Tail slot of the insert level, wrapped without a divider.
  assign back_sum = SUM_W'(head[ins_lvl]) + SUM_W'(count[ins_lvl]);
  assign back_slot = (back_sum >= SUM_DEPTH) ? HEAD_W'(back_sum - SUM_DEPTH)
                                             : HEAD_W'(back_sum);
  assign front_slot = (head[0] == '0) ? HEAD_LAST : head[0] - HEAD_W'(1);

  // Most urgent level that holds a tag.
  always_comb begin
    pop_lvl = '0;
    pop_any = 1'b0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (count[i] != '0) begin
        pop_lvl = LEVEL_W'(i);
        pop_any = 1'b1;
      end
    end
  end

  assign pop_head_inc = (head[pop_lvl] == HEAD_LAST) ? '0 : head[pop_lvl] + HEAD_W'(1);

  always_comb begin
    head_next = head;
    count_next = count;
    res.status = ST_OK;
    res.level = '0;
    res.bad = 1'b0;
    res.pop_hit = 1'b0;
    we = 1'b0;
    waddr = {ins_lvl, back_slot};
    raddr = {pop_lvl, head[pop_lvl]};
    unique case (cmd_t'(cmd))
      CMD_INSERT: begin
        res.bad = prio[PRIO_W-1];
        if (count[ins_lvl] == CNT_FULL) begin
          res.status = ST_FULL;
        end else begin
          we = go;
          count_next[ins_lvl] = count[ins_lvl] + CNT_W'(1);
        end
      end
      CMD_FRONT: begin
        waddr = {LEVEL_W'(0), front_slot};
        if (count[0] == CNT_FULL) begin
          res.status = ST_FULL;
        end else begin
          we = go;
          head_next[0] = front_slot;
          count_next[0] = count[0] + CNT_W'(1);
        end
      end
      CMD_POP: begin
        if (!pop_any) begin
          res.status = ST_EMPTY;
        end else begin
          res.pop_hit = 1'b1;
          res.level = pop_lvl;
          head_next[pop_lvl] = pop_head_inc;
          count_next[pop_lvl] = count[pop_lvl] - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
    res.empty = (count_next[0] == '0) && (count_next[1] == '0) &&
                (count_next[2] == '0) && (count_next[3] == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head[i] <= '0;
        count[i] <= '0;
      end
    end else if (go) begin
      head <= head_next;
      count <= count_next;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (count[0] <= CNT_FULL) && (count[1] <= CNT_FULL) &&
    (count[2] <= CNT_FULL) && (count[3] <= CNT_FULL))
    else $error("level count beyond depth");

  a_head_range: assert property (@(posedge clk) disable iff (rst)
    (head[0] <= HEAD_LAST) && (head[1] <= HEAD_LAST) &&
    (head[2] <= HEAD_LAST) && (head[3] <= HEAD_LAST))
    else $error("level head beyond depth");

  a_pop_dec: assert property (@(posedge clk) disable iff (rst)
    go && res.pop_hit |=> count[$past(res.level)] == $past(count[res.level]) - CNT_W'(1))
    else $error("pop did not take one tag from its level");

endmodule

/* hdl/four_level_strict_priority_queue.sv */
// Top level of the four-level strict priority queue: handshake, tag memory, result register.
//
//  channel  | valid     | stall     | payload
//  ---------+-----------+-----------+------------------------------------------------
//  in       | in_valid  | in_stall  | cmd, priority_req, frame_tag
//  out      | out_valid | out_stall | status, popped_tag, popped_level, bad_priority,
//           |           |           | all_empty
//
// Each command is held in the input register, then goes through the level logic into the
// result register and tag memory read. One command per cycle is sustained while the result
// is not stalled; the level head and count update sets that rate.
// Reset clears all levels at once; the tag memory needs no clearing pass.
// A stalled result holds the pipeline, while an empty input register still takes a transfer.
module four_level_strict_priority_queue import fspq_pkg::*; #(
  parameter int LEVEL_DEPTH = 16,
  parameter int TAG_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CMD_W-1:0]      cmd,
  input  logic [PRIO_W-1:0]     priority_req,
  input  logic [TAG_PORT_W-1:0] frame_tag,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            status,
  output logic [TAG_PORT_W-1:0] popped_tag,
  output logic [LEVEL_W-1:0]    popped_level,
  output logic                  bad_priority,
  output logic                  all_empty
);

  localparam int HEAD_W = $clog2(LEVEL_DEPTH);
  localparam int ADDR_W = LEVEL_W + HEAD_W;
  localparam int STORE_W = (TAG_WIDTH < TAG_PORT_W) ? TAG_WIDTH : TAG_PORT_W;
  localparam int MEM_DEPTH = NUM_LEVELS << HEAD_W;

  logic                  in_full;
  logic [CMD_W-1:0]      cmd_r;
  logic [PRIO_W-1:0]     prio_r;
  logic [STORE_W-1:0]    tag_r;
  logic                  proceed;
  logic                  accept;

  logic                  we;
  logic [ADDR_W-1:0]     waddr;
  logic [ADDR_W-1:0]     raddr;
  fspq_result_t          res;
  fspq_result_t          res_r;

  logic [STORE_W-1:0]    tag_mem [MEM_DEPTH];
  logic [STORE_W-1:0]    rd_tag;

  assign proceed = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !proceed;
  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      in_full <= accept || (in_full && !proceed);
      out_valid <= proceed || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cmd;
      prio_r <= priority_req;
      tag_r <= frame_tag[STORE_W-1:0];
    end
    if (proceed) begin
      res_r <= res;
    end
  end

  fspq_level_ctl #(
    .LEVEL_DEPTH (LEVEL_DEPTH)
  ) u_level_ctl (
    .clk   (clk),
    .rst   (rst),
    .go    (proceed),
    .cmd   (cmd_r),
    .prio  (prio_r),
    .we    (we),
    .waddr (waddr),
    .raddr (raddr),
    .res   (res)
  );

  // A pop reads the head slot in the same cycle the result register loads.
  always_ff @(posedge clk) begin
    if (we) begin
      tag_mem[waddr] <= tag_r;
    end
    if (proceed && res.pop_hit) begin
      rd_tag <= tag_mem[raddr];
    end
  end

  assign status = res_r.status;
  assign popped_tag = res_r.pop_hit ? TAG_PORT_W'(rd_tag) : '0;
  assign popped_level = res_r.level;
  assign bad_priority = res_r.bad;
  assign all_empty = res_r.empty;

  a_idle_no_stall: assert property (@(posedge clk) disable iff (rst)
    !in_full |-> !in_stall)
    else $error("empty input register refused a transfer");

  a_tag_only_on_pop: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> (popped_tag == '0) && (popped_level == '0))
    else $error("tag shown on a failed command");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid && !in_full)
    else $error("pipeline not cleared by reset");

endmodule
